// ===== hdl/tmhq_pkg.sv =====
// Package: request and status codes, state encoding and sizes for the timer heap queue.
`timescale 1ns / 1ps
package tmhq_pkg;
   localparam int HEAP_DEPTH = 16;
   localparam int IDX_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int EXP_W = 41;
   localparam int ID_W = 16;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_CANCEL = 2'd1,
      REQ_TICK   = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_code_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_CAN_RD,
      S_CAN_CMP,
      S_TK_RD,
      S_TK_CHK,
      S_POP,
      S_DN_RD,
      S_DN_CMP,
      S_DN_SWAP,
      S_FINAL
   } state_type;
endpackage

// ===== hdl/timer_min_heap_queue_unit.sv =====
// Top level: timer queue kept as a binary min-heap with lazy cancellation.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; busy stays high while the request
// is worked on. Each result is strobed for one cycle on rsp_valid, and rsp_last marks the
// final one. The receiver cannot stall. An add result comes in the cycle after acceptance,
// while busy may still be high for the sift up. A cancel or tick final result comes in the
// cycle in which busy drops. The heap lives in one register-file memory. A small sequencer
// walks it with one shared expiry comparator and handles one slot read, compare or move per
// cycle. An add climbs one heap level at a time and stops at the root. A cancel scans the
// slots in order until a live entry with the id is found. A tick pops each expired or
// cancelled top entry and sinks its replacement level by level, then checks the top, if
// any, before the final result.
// No clearing pass is needed after reset.
module timer_min_heap_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [39:0] req_now_ms,
   input  logic [31:0] req_timeout_ms,
   input  logic [15:0] req_cancel_id,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_tag,
   output logic        rsp_fired,
   output logic        rsp_has_pending,
   output logic [31:0] rsp_wait_ms,
   output logic        rsp_last
);
   localparam int IW = tmhq_pkg::IDX_W;
   localparam int CW = tmhq_pkg::CNT_W;
   localparam int EW = tmhq_pkg::EXP_W;
   localparam int DW = EW + tmhq_pkg::ID_W + 1;

   // slot word: {live, id, expiry}
   logic [DW-1:0] mem [tmhq_pkg::HEAP_DEPTH];

   tmhq_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   last_id_ff, last_id_in;
   logic [IW-1:0] k_ff, k_in;      // current slot
   logic [IW-1:0] s_ff, s_in;      // best child slot
   logic [CW-1:0] scan_ff, scan_in;
   logic [39:0]   now_ff, now_in;
   logic [15:0]   cid_ff, cid_in;
   logic [1:0]    phase_ff, phase_in; // sift-down child step, 3 for the sift-up root write
   logic [DW-1:0] a_ff, a_in;      // word at k
   logic [DW-1:0] b_ff, b_in;      // compared word
   logic [DW-1:0] rd_ff;
   logic          is_tick_ff, is_tick_in;

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [DW-1:0] wr_data;

   logic          rsp_valid_in;
   logic [1:0]    rsp_status_in;
   logic [15:0]   rsp_tag_in;
   logic          rsp_fired_in, rsp_has_pending_in, rsp_last_in;
   logic [31:0]   rsp_wait_ms_in;

   // shared comparator
   logic [EW-1:0] cmp_x, cmp_y;
   logic          cmp_lt;
   assign cmp_lt = cmp_x < cmp_y;

   logic [EW:0]   diff;
   assign diff = {1'b0, a_ff[EW-1:0]} - {2'b00, now_ff};

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmhq_pkg::S_IDLE;
         count_ff <= '0;
         last_id_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_id_ff <= last_id_in;
         rsp_valid <= rsp_valid_in;
      end
      k_ff <= k_in;
      s_ff <= s_in;
      scan_ff <= scan_in;
      now_ff <= now_in;
      cid_ff <= cid_in;
      phase_ff <= phase_in;
      a_ff <= a_in;
      b_ff <= b_in;
      is_tick_ff <= is_tick_in;
      rsp_status <= rsp_status_in;
      rsp_tag <= rsp_tag_in;
      rsp_fired <= rsp_fired_in;
      rsp_has_pending <= rsp_has_pending_in;
      rsp_wait_ms <= rsp_wait_ms_in;
      rsp_last <= rsp_last_in;
   end

   assign busy = (state_ff != tmhq_pkg::S_IDLE);

   always_comb begin
      logic [CW:0] lc, rc;
      logic [IW-1:0] parent;
      state_in = state_ff;
      count_in = count_ff;
      last_id_in = last_id_ff;
      k_in = k_ff;
      s_in = s_ff;
      scan_in = scan_ff;
      now_in = now_ff;
      cid_in = cid_ff;
      phase_in = phase_ff;
      a_in = a_ff;
      b_in = b_ff;
      is_tick_in = is_tick_ff;
      rd_en = 1'b0;
      rd_addr = k_ff;
      wr_en = 1'b0;
      wr_addr = k_ff;
      wr_data = a_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = tmhq_pkg::ST_OK;
      rsp_tag_in = '0;
      rsp_fired_in = 1'b0;
      rsp_has_pending_in = 1'b0;
      rsp_wait_ms_in = '0;
      rsp_last_in = 1'b0;
      cmp_x = a_ff[EW-1:0];
      cmp_y = b_ff[EW-1:0];
      parent = IW'((k_ff - IW'(1)) >> 1);
      lc = {1'b0, k_ff, 1'b1};
      rc = (CW+1)'({k_ff, 1'b1}) + (CW+1)'(1);

      case (state_ff)
         tmhq_pkg::S_IDLE: begin
            if (start) begin
               now_in = req_now_ms;
               cid_in = req_cancel_id;
               case (req_type)
                  tmhq_pkg::REQ_ADD: begin
                     if (count_ff >= CW'(tmhq_pkg::HEAP_DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = tmhq_pkg::ST_FULL;
                        rsp_last_in = 1'b1;
                     end else begin
                        last_id_in = (last_id_ff == 16'hFFFF) ? 16'd1 : last_id_ff + 16'd1;
                        a_in = {1'b1, last_id_in,
                                EW'({1'b0, req_now_ms} + {9'd0, req_timeout_ms})};
                        k_in = count_ff[IW-1:0];
                        wr_en = 1'b1;
                        wr_addr = count_ff[IW-1:0];
                        wr_data = a_in;
                        count_in = count_ff + CW'(1);
                        rsp_valid_in = 1'b1;
                        rsp_tag_in = last_id_in;
                        rsp_last_in = 1'b1;
                        if (count_ff != '0) state_in = tmhq_pkg::S_UP_RD;
                     end
                  end
                  tmhq_pkg::REQ_CANCEL: begin
                     scan_in = '0;
                     state_in = tmhq_pkg::S_CAN_RD;
                  end
                  tmhq_pkg::REQ_TICK: begin
                     is_tick_in = 1'b1;
                     state_in = tmhq_pkg::S_TK_RD;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in = 1'b1;
                  end
               endcase
            end
         end
         // sift up: a_ff holds the moving entry at slot k
         tmhq_pkg::S_UP_RD: begin
            rd_en = 1'b1;
            rd_addr = parent;
            state_in = tmhq_pkg::S_UP_CMP;
         end
         tmhq_pkg::S_UP_CMP: begin
            cmp_y = rd_ff[EW-1:0];
            if (cmp_lt) begin
               wr_en = 1'b1;
               wr_addr = k_ff;
               wr_data = rd_ff;
               k_in = parent;
               if (parent == '0) begin
                  state_in = tmhq_pkg::S_DN_SWAP; // write a_ff at slot 0
                  phase_in = 2'd3;
               end else state_in = tmhq_pkg::S_UP_RD;
            end else begin
               wr_en = 1'b1;
               wr_addr = k_ff;
               wr_data = a_ff;
               state_in = tmhq_pkg::S_IDLE;
            end
         end
         tmhq_pkg::S_CAN_RD: begin
            if (scan_ff >= count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = tmhq_pkg::ST_NOT_FOUND;
               rsp_last_in = 1'b1;
               state_in = tmhq_pkg::S_IDLE;
            end else begin
               rd_en = 1'b1;
               rd_addr = scan_ff[IW-1:0];
               state_in = tmhq_pkg::S_CAN_CMP;
            end
         end
         tmhq_pkg::S_CAN_CMP: begin
            if (rd_ff[DW-1] && rd_ff[EW +: 16] == cid_ff) begin
               wr_en = 1'b1;
               wr_addr = scan_ff[IW-1:0];
               wr_data = {1'b0, rd_ff[DW-2:0]};
               rsp_valid_in = 1'b1;
               rsp_last_in = 1'b1;
               state_in = tmhq_pkg::S_IDLE;
            end else begin
               scan_in = scan_ff + CW'(1);
               state_in = tmhq_pkg::S_CAN_RD;
            end
         end
         // tick: read the top, decide to fire, drop or finish
         tmhq_pkg::S_TK_RD: begin
            if (count_ff == '0) state_in = tmhq_pkg::S_FINAL;
            else begin
               rd_en = 1'b1;
               rd_addr = '0;
               state_in = tmhq_pkg::S_TK_CHK;
            end
         end
         tmhq_pkg::S_TK_CHK: begin
            a_in = rd_ff;
            cmp_x = {1'b0, now_ff};
            cmp_y = rd_ff[EW-1:0];
            if (is_tick_ff && !cmp_lt) begin
               if (rd_ff[DW-1]) begin
                  rsp_valid_in = 1'b1;
                  rsp_tag_in = rd_ff[EW +: 16];
                  rsp_fired_in = 1'b1;
               end
               state_in = tmhq_pkg::S_POP;
            end else begin
               is_tick_in = 1'b0;
               state_in = rd_ff[DW-1] ? tmhq_pkg::S_FINAL : tmhq_pkg::S_POP;
            end
         end
         tmhq_pkg::S_POP: begin
            count_in = count_ff - CW'(1);
            k_in = '0;
            if (count_in == '0) state_in = tmhq_pkg::S_TK_RD;
            else begin
               rd_en = 1'b1;
               rd_addr = count_in[IW-1:0];
               phase_in = 2'd0;
               state_in = tmhq_pkg::S_DN_RD;
            end
         end
         // sift down: phase 0 load moving entry, 1 left child, 2 right child
         tmhq_pkg::S_DN_RD: begin
            if (phase_ff == 2'd0) begin
               a_in = rd_ff;
               b_in = rd_ff;
               s_in = k_ff;
               if (lc < (CW+1)'(count_ff)) begin
                  rd_en = 1'b1;
                  rd_addr = lc[IW-1:0];
                  phase_in = 2'd1;
                  state_in = tmhq_pkg::S_DN_CMP;
               end else state_in = tmhq_pkg::S_DN_SWAP;
            end else if (rc < (CW+1)'(count_ff)) begin
               rd_en = 1'b1;
               rd_addr = rc[IW-1:0];
               phase_in = 2'd2;
               state_in = tmhq_pkg::S_DN_CMP;
            end else state_in = tmhq_pkg::S_DN_SWAP;
         end
         tmhq_pkg::S_DN_CMP: begin
            cmp_x = rd_ff[EW-1:0];
            cmp_y = b_ff[EW-1:0];
            if (cmp_lt) begin
               b_in = rd_ff;
               s_in = (phase_ff == 2'd1) ? lc[IW-1:0] : rc[IW-1:0];
            end
            state_in = (phase_ff == 2'd1) ? tmhq_pkg::S_DN_RD : tmhq_pkg::S_DN_SWAP;
         end
         tmhq_pkg::S_DN_SWAP: begin
            wr_en = 1'b1;
            wr_addr = k_ff;
            if (phase_ff == 2'd3 || s_ff == k_ff) begin
               wr_data = a_ff;
               state_in = (phase_ff == 2'd3) ? tmhq_pkg::S_IDLE : tmhq_pkg::S_TK_RD;
            end else begin
               // move smaller child up, continue from its slot
               wr_data = b_ff;
               k_in = s_ff;
               b_in = a_ff;
               phase_in = 2'd1;
               state_in = ({1'b0, s_ff, 1'b1} < (CW+1)'(count_ff))
                          ? tmhq_pkg::S_DN_RD : tmhq_pkg::S_DN_SWAP;
               if ({1'b0, s_ff, 1'b1} < (CW+1)'(count_ff)) begin
                  rd_en = 1'b1;
                  rd_addr = IW'({s_ff, 1'b1});
                  state_in = tmhq_pkg::S_DN_CMP;
               end
               s_in = s_ff;
            end
         end
         tmhq_pkg::S_FINAL: begin
            rsp_valid_in = 1'b1;
            rsp_last_in = 1'b1;
            rsp_has_pending_in = (count_ff != '0);
            if (count_ff != '0 && !diff[EW])
               rsp_wait_ms_in = (diff[EW-1:32] != '0) ? 32'hFFFF_FFFF : diff[31:0];
            state_in = tmhq_pkg::S_IDLE;
         end
         default: state_in = tmhq_pkg::S_IDLE;
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(tmhq_pkg::HEAP_DEPTH)) else $error("entry count over depth");
   a_mid_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy) else $error("non-final result while idle");
   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fired) |-> !rsp_last) else $error("fire result marked last");
   a_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      (last_id_ff != '0) |=> (last_id_ff != '0)) else $error("id returned to zero");
endmodule

// ===== tb/timer_min_heap_queue_unit_tb.sv =====
// Testbench: timer heap queue checked against a behavioral heap predictor under random idling.
`timescale 1ns / 1ps
module timer_min_heap_queue_unit_tb;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] tag;
      logic        fired;
      logic        has_pending;
      logic [31:0] wait_ms;
      logic        last;
   } timer_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = tmhq_pkg::REQ_ADD;
   logic [39:0] req_now_ms = '0;
   logic [31:0] req_timeout_ms = '0;
   logic [15:0] req_cancel_id = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_tag;
   logic        rsp_fired;
   logic        rsp_has_pending;
   logic [31:0] rsp_wait_ms;
   logic        rsp_last;

   timer_min_heap_queue_unit dut (.*);

   // predictor state
   logic [40:0] heap_expiry [tmhq_pkg::HEAP_DEPTH];
   logic [15:0] heap_id [tmhq_pkg::HEAP_DEPTH];
   logic        heap_live [tmhq_pkg::HEAP_DEPTH];
   int          heap_count;
   logic [15:0] prev_id;

   timer_result_type expected_results [$];
   int  error_count = 0;
   int  sender_idle_pct = 0;
   longint cycle_count = 0;
   logic [39:0] clock_ms = 40'd1000;

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic void heap_swap(int a, int b);
      logic [40:0] e;
      logic [15:0] i;
      logic        l;
      e = heap_expiry[a]; i = heap_id[a]; l = heap_live[a];
      heap_expiry[a] = heap_expiry[b]; heap_id[a] = heap_id[b]; heap_live[a] = heap_live[b];
      heap_expiry[b] = e; heap_id[b] = i; heap_live[b] = l;
   endfunction

   function automatic void heap_pop();
      int k, l, r, s;
      heap_count--;
      if (heap_count > 0) begin
         heap_expiry[0] = heap_expiry[heap_count];
         heap_id[0] = heap_id[heap_count];
         heap_live[0] = heap_live[heap_count];
         k = 0;
         forever begin
            l = 2 * k + 1; r = 2 * k + 2; s = k;
            if (l < heap_count && heap_expiry[l] < heap_expiry[s]) s = l;
            if (r < heap_count && heap_expiry[r] < heap_expiry[s]) s = r;
            if (s == k) break;
            heap_swap(k, s);
            k = s;
         end
      end
   endfunction

   function automatic void push_result(logic [1:0] st, logic [15:0] id, logic f,
                                       logic p, logic [31:0] w, logic lst);
      timer_result_type r;
      r = '{st, id, f, p, w, lst};
      expected_results.push_back(r);
   endfunction

   function automatic void predict_timer_request(logic [1:0] kind, logic [39:0] now,
                                                 logic [31:0] tmo, logic [15:0] cid);
      int k, p;
      bit hit;
      logic [40:0] d;
      case (kind)
         tmhq_pkg::REQ_ADD: begin
            if (heap_count >= tmhq_pkg::HEAP_DEPTH) begin
               push_result(tmhq_pkg::ST_FULL, 16'd0, 1'b0, 1'b0, 32'd0, 1'b1);
            end else begin
               prev_id = (prev_id == 16'hFFFF) ? 16'd1 : prev_id + 16'd1;
               k = heap_count;
               heap_expiry[k] = {1'b0, now} + {9'd0, tmo};
               heap_id[k] = prev_id;
               heap_live[k] = 1'b1;
               heap_count++;
               while (k > 0) begin
                  p = (k - 1) / 2;
                  if (heap_expiry[k] >= heap_expiry[p]) break;
                  heap_swap(k, p);
                  k = p;
               end
               push_result(tmhq_pkg::ST_OK, prev_id, 1'b0, 1'b0, 32'd0, 1'b1);
            end
         end
         tmhq_pkg::REQ_CANCEL: begin
            hit = 1'b0;
            for (int i = 0; i < heap_count; i++) begin
               if (!hit && heap_id[i] == cid && heap_live[i]) begin
                  heap_live[i] = 1'b0;
                  hit = 1'b1;
               end
            end
            push_result(hit ? tmhq_pkg::ST_OK : tmhq_pkg::ST_NOT_FOUND, 16'd0, 1'b0, 1'b0,
                        32'd0, 1'b1);
         end
         tmhq_pkg::REQ_TICK: begin
            while (heap_count > 0 && heap_expiry[0] <= {1'b0, now}) begin
               if (heap_live[0])
                  push_result(tmhq_pkg::ST_OK, heap_id[0], 1'b1, 1'b0, 32'd0, 1'b0);
               heap_pop();
            end
            while (heap_count > 0 && !heap_live[0]) heap_pop();
            d = 41'd0;
            if (heap_count > 0 && heap_expiry[0] > {1'b0, now})
               d = heap_expiry[0] - {1'b0, now};
            push_result(tmhq_pkg::ST_OK, 16'd0, 1'b0, heap_count > 0,
                        (d > 41'hFFFFFFFF) ? 32'hFFFFFFFF : d[31:0], 1'b1);
         end
         default: push_result(tmhq_pkg::ST_OK, 16'd0, 1'b0, 1'b0, 32'd0, 1'b1);
      endcase
   endfunction

   // check each result transaction against the oldest expectation
   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction, tag %0d", rsp_tag);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_tag !== want.tag) begin
               $error("tag: expected %0d, got %0d", want.tag, rsp_tag);
               error_count++;
            end
            if (rsp_fired !== want.fired) begin
               $error("fired: expected %0d, got %0d", want.fired, rsp_fired);
               error_count++;
            end
            if (rsp_has_pending !== want.has_pending) begin
               $error("has_pending: expected %0d, got %0d", want.has_pending,
                      rsp_has_pending);
               error_count++;
            end
            if (rsp_wait_ms !== want.wait_ms) begin
               $error("wait_ms: expected %0d, got %0d", want.wait_ms, rsp_wait_ms);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // start stays high between back-to-back transactions; drop it only to idle
   task automatic send_request(logic [1:0] kind, logic [39:0] now, logic [31:0] tmo,
                               logic [15:0] cid);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_type <= kind;
      req_now_ms <= now;
      req_timeout_ms <= tmo;
      req_cancel_id <= cid;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_timer_request(kind, now, tmo, cid);
   endtask

   // pick a live-looking id most of the time so cancels land
   function automatic logic [15:0] pick_cancel_id();
      if (heap_count > 0 && $urandom_range(3) != 0) return heap_id[$urandom_range(heap_count - 1)];
      return 16'($urandom);
   endfunction

   task automatic test_directed();
      send_request(tmhq_pkg::REQ_TICK, 40'd0, 32'd0, 16'd0);
      send_request(tmhq_pkg::REQ_CANCEL, 40'd0, 32'd0, 16'd1);
      send_request(tmhq_pkg::REQ_ADD, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(tmhq_pkg::REQ_ADD, 40'd100, 32'd0, 16'd0);
      send_request(tmhq_pkg::REQ_ADD, 40'd100, 32'd50, 16'd0);
      send_request(tmhq_pkg::REQ_ADD, 40'd100, 32'd50, 16'd0);
      send_request(tmhq_pkg::REQ_CANCEL, 40'd0, 32'd0, 16'd3);
      send_request(tmhq_pkg::REQ_CANCEL, 40'd0, 32'd0, 16'd3);
      send_request(tmhq_pkg::REQ_NONE, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(tmhq_pkg::REQ_TICK, 40'd120, 32'd0, 16'd0);
      send_request(tmhq_pkg::REQ_TICK, 40'd150, 32'd0, 16'd0);
      // wait saturates: far-off expiry seen from time zero
      send_request(tmhq_pkg::REQ_TICK, 40'd0, 32'd0, 16'd0);
      for (int i = 0; i < 17; i++)
         send_request(tmhq_pkg::REQ_ADD, 40'd200, 32'(i % 3), 16'd0);
      send_request(tmhq_pkg::REQ_TICK, 40'hFF_FFFF_FFFF, 32'd0, 16'd0);
   endtask

   task automatic test_random(int n_items, int idle_pct);
      int r;
      sender_idle_pct = idle_pct;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(99);
         if (r < 45) send_request(tmhq_pkg::REQ_ADD, clock_ms,
                                  $urandom_range(3) == 0 ? $urandom :
                                  32'($urandom_range(200)), 16'd0);
         else if (r < 65) send_request(tmhq_pkg::REQ_CANCEL, 40'd0, 32'd0, pick_cancel_id());
         else if (r < 92) begin
            clock_ms = clock_ms + 40'($urandom_range(120));
            send_request(tmhq_pkg::REQ_TICK, clock_ms, 32'd0, 16'd0);
         end else if (r < 96) send_request(tmhq_pkg::REQ_TICK, 40'({$urandom, $urandom}),
                                           32'd0, 16'd0);
         else send_request(tmhq_pkg::REQ_NONE, 40'({$urandom, $urandom}), $urandom,
                           16'($urandom));
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      heap_count = 0;
      prev_id = 16'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(90, 0);
      test_random(80, 78);
      test_random(80, 14);
      test_random(40, 0);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
